// File: design/ddw_pkg.sv
package ddw_pkg;

  // One transaction on the request side: two Gregorian date-times.
  typedef struct packed {
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [13:0] first_year;
    logic [4:0]  first_hour;
    logic [5:0]  first_minute;
    logic [5:0]  first_second;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [13:0] other_year;
    logic [4:0]  other_hour;
    logic [5:0]  other_minute;
    logic [5:0]  other_second;
  } req_t;

  // One transaction on the response side.
  typedef struct packed {
    logic signed [22:0] day_difference;
    logic [2:0]         first_weekday;
    logic [2:0]         other_weekday;
    logic               both_valid;
  } rsp_t;

  localparam int unsigned MaxYear     = 9999;
  localparam int unsigned EpochYears  = 4800;
  localparam int unsigned JdnOffset   = 32045;
  localparam int unsigned SecsHour    = 3600;
  localparam int unsigned SecsMinute  = 60;
  localparam int unsigned DaysYear    = 365;
  // ceil(2^16 / 25); exact floor(x / 25) for every x below 4681.
  localparam int unsigned Recip25     = 2622;
  localparam int unsigned Recip25Bits = 16;

  // Days in month for months 1..12 of a common year; 0 for other codes.
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // (153 * m + 2) / 5 for the March-based month index m = 0..11.
  function automatic logic [8:0] month_offset(input logic [3:0] idx);
    logic [8:0] off;
    case (idx)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // Remainder modulo 7 of a 23-bit value: 8 = 1 (mod 7), so octal digits add up.
  function automatic logic [2:0] mod7(input logic [22:0] val);
    logic [5:0] sum;
    logic [3:0] fold;
    logic [2:0] res;
    sum = 6'(val[2:0]) + 6'(val[5:3]) + 6'(val[8:6]) + 6'(val[11:9])
        + 6'(val[14:12]) + 6'(val[17:15]) + 6'(val[20:18]) + 6'(val[22:21]);
    fold = 4'(sum[5:3]) + 4'(sum[2:0]);
    res = 3'(fold[3]) + fold[2:0];
    return (res == 3'd7) ? 3'd0 : res;
  endfunction

endpackage

// File: design/date_difference_and_weekday_unit.sv
// Date difference and weekday unit. Each request transaction carries two
// Gregorian date-times; the matching response gives the whole-day difference
// (first minus second, truncated toward zero), the weekday of each date
// (0 Monday through 6 Sunday) and a flag that is set only when both
// date-times are valid. When either one is invalid, every response field is
// zero. The unit is a four-stage pipeline that accepts one transaction per
// clock while the response side does not stall and returns each response
// in request order. Stage one checks the inputs, stage two forms the
// year-day sums with a reciprocal multiply for the century terms, stage
// three completes the Julian day numbers and stage four is the output
// register, which subtracts them and reduces each modulo 7. Stalls on the
// response side only hold the stages that are full, so empty slots close up
// and no transaction is lost or repeated.
module date_difference_and_weekday_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ddw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ddw_pkg::rsp_t rsp
);

  // Per-date input fields; lane 0 is the first date-time, lane 1 the other.
  logic [4:0]  in_day    [2];
  logic [3:0]  in_month  [2];
  logic [13:0] in_year   [2];
  logic [4:0]  in_hour   [2];
  logic [5:0]  in_minute [2];
  logic [5:0]  in_second [2];

  assign in_day[0]    = req.first_day;
  assign in_month[0]  = req.first_month;
  assign in_year[0]   = req.first_year;
  assign in_hour[0]   = req.first_hour;
  assign in_minute[0] = req.first_minute;
  assign in_second[0] = req.first_second;
  assign in_day[1]    = req.other_day;
  assign in_month[1]  = req.other_month;
  assign in_year[1]   = req.other_year;
  assign in_hour[1]   = req.other_hour;
  assign in_minute[1] = req.other_minute;
  assign in_second[1] = req.other_second;

  // Stage occupancy and the advance chain. A stage may load whenever it is
  // empty or its contents move on in the same cycle.
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic adv1, adv2, adv3, adv4;

  assign adv4      = !s4_valid || rsp_ready;
  assign adv3      = !s3_valid || adv4;
  assign adv2      = !s2_valid || adv3;
  assign adv1      = !s1_valid || adv2;
  assign req_ready = adv1;
  assign rsp_valid = s4_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= req_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        s3_valid <= s2_valid;
      end
      if (adv4) begin
        s4_valid <= s3_valid;
      end
    end
  end

  // Stage 1: validity checks, March-based year and month, seconds of day.
  // The leap rule needs year / 100, taken as (year / 4) / 25 by reciprocal.
  logic        s1_ok_next    [2];
  logic [14:0] s1_year_next  [2];
  logic [3:0]  s1_midx_next  [2];
  logic [16:0] s1_secs_next  [2];

  logic        s1_ok   [2];
  logic [14:0] s1_year [2];
  logic [3:0]  s1_midx [2];
  logic [4:0]  s1_day  [2];
  logic [16:0] s1_secs [2];

  always_comb begin
    logic [11:0] quarter;
    logic [23:0] prod;
    logic [7:0]  cent;
    logic        cent_exact;
    logic        leap;
    logic [4:0]  lim;
    logic        date_ok;
    logic        time_ok;
    logic        early;
    for (int i = 0; i < 2; i++) begin
      quarter    = in_year[i][13:2];
      prod       = 24'(quarter) * 24'(ddw_pkg::Recip25);
      cent       = prod[23:ddw_pkg::Recip25Bits];
      cent_exact = (quarter == 12'(16'(cent) * 16'd25));
      // Divisible by 4, and either not by 100 or also by 400.
      leap = (in_year[i][1:0] == 2'd0) && (!cent_exact || (cent[1:0] == 2'd0));
      lim  = ddw_pkg::month_len(in_month[i]);
      if ((in_month[i] == 4'd2) && leap) begin
        lim = 5'd29;
      end
      date_ok = (in_day[i] != 5'd0) && (in_day[i] <= lim) && (lim != 5'd0)
             && (in_year[i] != 14'd0) && (in_year[i] <= 14'(ddw_pkg::MaxYear));
      time_ok = (in_hour[i] <= 5'd23) && (in_minute[i] <= 6'd59)
             && (in_second[i] <= 6'd59);
      s1_ok_next[i] = date_ok && time_ok;
      // January and February count as months 10 and 11 of the prior year.
      early = (in_month[i] <= 4'd2);
      s1_year_next[i] = 15'(in_year[i]) + 15'(ddw_pkg::EpochYears) - 15'(early);
      s1_midx_next[i] = early ? 4'(in_month[i] + 4'd9) : 4'(in_month[i] - 4'd3);
      s1_secs_next[i] = 17'(in_hour[i] * 17'(ddw_pkg::SecsHour))
                      + 17'(in_minute[i] * 17'(ddw_pkg::SecsMinute))
                      + 17'(in_second[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < 2; i++) begin
        s1_ok[i]   <= s1_ok_next[i];
        s1_year[i] <= s1_year_next[i];
        s1_midx[i] <= s1_midx_next[i];
        s1_day[i]  <= in_day[i];
        s1_secs[i] <= s1_secs_next[i];
      end
    end
  end

  // Stage 2: day count of whole years and months, the leap-day terms of the
  // shifted year, and the ordering of the two times of day.
  logic [23:0] s2_base_next [2];
  logic [12:0] s2_y4_next   [2];
  logic [8:0]  s2_y100_next [2];

  logic [23:0] s2_base [2];
  logic [12:0] s2_y4   [2];
  logic [8:0]  s2_y100 [2];
  logic        s2_ok;
  logic        s2_secs_gt;
  logic        s2_secs_lt;

  always_comb begin
    logic [24:0] prod;
    for (int i = 0; i < 2; i++) begin
      s2_y4_next[i]   = s1_year[i][14:2];
      prod            = 25'(s2_y4_next[i]) * 25'(ddw_pkg::Recip25);
      s2_y100_next[i] = prod[24:ddw_pkg::Recip25Bits];
      s2_base_next[i] = 24'(s1_year[i] * 24'(ddw_pkg::DaysYear))
                      + 24'(ddw_pkg::month_offset(s1_midx[i]))
                      + 24'(s1_day[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int i = 0; i < 2; i++) begin
        s2_base[i] <= s2_base_next[i];
        s2_y4[i]   <= s2_y4_next[i];
        s2_y100[i] <= s2_y100_next[i];
      end
      s2_ok      <= s1_ok[0] && s1_ok[1];
      s2_secs_gt <= (s1_secs[0] > s1_secs[1]);
      s2_secs_lt <= (s1_secs[0] < s1_secs[1]);
    end
  end

  // Stage 3: Julian day numbers.
  logic [22:0] s3_jdn_next [2];
  logic [22:0] s3_jdn      [2];
  logic        s3_ok;
  logic        s3_secs_gt;
  logic        s3_secs_lt;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s3_jdn_next[i] = 23'(s2_base[i] + 24'(s2_y4[i]) - 24'(s2_y100[i])
                     + 24'(s2_y100[i][8:2]) - 24'(ddw_pkg::JdnOffset));
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_jdn[0]  <= s3_jdn_next[0];
      s3_jdn[1]  <= s3_jdn_next[1];
      s3_ok      <= s2_ok;
      s3_secs_gt <= s2_secs_gt;
      s3_secs_lt <= s2_secs_lt;
    end
  end

  // Stage 4: the output register. The seconds of day differ by less than one
  // day, so truncation toward zero moves the day difference one step toward
  // zero exactly when the time-of-day difference has the opposite sign.
  ddw_pkg::rsp_t rsp_next;

  always_comb begin
    logic signed [23:0] dj;
    logic signed [23:0] adj;
    dj  = $signed({1'b0, s3_jdn[0]}) - $signed({1'b0, s3_jdn[1]});
    adj = dj;
    if ((dj > 24'sd0) && s3_secs_lt) begin
      adj = dj - 24'sd1;
    end else if ((dj < 24'sd0) && s3_secs_gt) begin
      adj = dj + 24'sd1;
    end
    if (s3_ok) begin
      rsp_next.day_difference = adj[22:0];
      rsp_next.first_weekday  = ddw_pkg::mod7(s3_jdn[0]);
      rsp_next.other_weekday  = ddw_pkg::mod7(s3_jdn[1]);
      rsp_next.both_valid     = 1'b1;
    end else begin
      rsp_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      rsp <= rsp_next;
    end
  end

endmodule
